[rtl/acmc_pkg.sv]
// Package for the auto charge mode controller.
// Sizes, codes, item/result/command structs and the BCD decode function.
// No dependencies.
package acmc_pkg;

  localparam int NUM_SCHEDULES = 10;
  localparam int DWELL_TICKS   = 10;

  localparam int IDX_W   = (NUM_SCHEDULES > 1) ? $clog2(NUM_SCHEDULES) : 1;
  localparam int DWELL_W = $clog2(DWELL_TICKS + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_EQUAL_SP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_SP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_SP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_OVR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CUT_CUR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CUT_TIME   = 3'd5;

  localparam logic [1:0] PH_WAIT     = 2'd0;
  localparam logic [1:0] PH_EQUALIZE = 2'd1;
  localparam logic [1:0] PH_DONE     = 2'd2;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // 98% threshold: 100 * volt > 98 * setpoint
  localparam logic [6:0] VOLT_SCALE = 7'd100;
  localparam logic [6:0] EQ_PCT     = 7'd98;

  typedef struct packed {
    logic        kind;
    logic [3:0]  entry_index;
    logic [6:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        manual_select;
    logic [15:0] battery_current;
    logic [15:0] output_voltage;
    logic [15:0] elapsed_cut_time;
  } item_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic        float_mode;
    logic        manual_active;
    logic [14:0] voltage_setpoint;
    logic        setpoint_applied;
    logic        restart_timers;
  } res_t;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } entry_t;

  typedef struct packed {
    logic             capture;
    logic             scan_en;
    logic [IDX_W-1:0] scan_idx;
    logic             commit;
  } ctrl_cmd_t;

  // Nibbles above nine are taken at their binary value.
  function automatic logic [14:0] bcd_tenths(input logic [15:0] v);
    logic [14:0] d3, d2, d1, d0;
    d3 = 15'(v[15:12]) * 15'd1000;
    d2 = 15'(v[11:8]) * 15'd100;
    d1 = 15'(v[7:4]) * 15'd10;
    d0 = 15'(v[3:0]);
    return d3 + d2 + d1 + d0;
  endfunction

endpackage

[rtl/acmc_if.sv]
// Channel interfaces for the auto charge mode controller.
// acmc_in_if carries input items, acmc_out_if carries results. No dependencies.
interface acmc_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  entry_index;
  logic [6:0]  year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic        manual_select;
  logic [15:0] battery_current;
  logic [15:0] output_voltage;
  logic [15:0] elapsed_cut_time;

  modport source (output valid, kind, entry_index, year, month, day, hour, minute,
                  second, manual_select, battery_current, output_voltage,
                  elapsed_cut_time, input ready);
  modport sink (input valid, kind, entry_index, year, month, day, hour, minute,
                second, manual_select, battery_current, output_voltage,
                elapsed_cut_time, output ready);
endinterface

interface acmc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  phase;
  logic        float_mode;
  logic        manual_active;
  logic [14:0] voltage_setpoint;
  logic        setpoint_applied;
  logic        restart_timers;

  modport source (output valid, phase, float_mode, manual_active, voltage_setpoint,
                  setpoint_applied, restart_timers, input ready);
  modport sink (input valid, phase, float_mode, manual_active, voltage_setpoint,
                setpoint_applied, restart_timers, output ready);
endinterface

[rtl/acmc_ctrl.sv]
// Sequencer for the auto charge mode controller: accept, prep, table scan, commit.
// Drives handshakes and datapath commands. Depends on acmc_pkg.
module acmc_ctrl
  import acmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ctrl_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SCHEDULES - 1);

  logic [1:0]       state;
  logic [IDX_W-1:0] cnt;

  assign in_ready     = (state == ST_IDLE) && !rst;
  assign cmd.capture  = in_valid && in_ready;
  assign cmd.scan_en  = (state == ST_SCAN);
  assign cmd.scan_idx = cnt;
  assign cmd.commit   = (state == ST_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd.capture) state <= ST_PREP;
        end
        ST_PREP: begin
          cnt   <= '0;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (cnt == LAST_IDX) begin
            state <= ST_DONE;
          end else begin
            cnt <= cnt + IDX_W'(1);
          end
        end
        ST_DONE: begin
          if (cmd.commit) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_capture_to_prep: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == ST_PREP && !in_ready))
    else $error("capture did not enter prep");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_en && cnt == LAST_IDX) |=> (state == ST_DONE))
    else $error("scan did not end at last entry");

  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (out_valid && in_ready))
    else $error("commit did not present a result");

endmodule

[rtl/acmc_dp.sv]
// Datapath for the auto charge mode controller: config registers, schedule table,
// match accumulator, threshold products, mode state and result register. Depends on acmc_pkg.
module acmc_dp
  import acmc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  input  item_t                 item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output res_t                  res
);

  logic [15:0] eq_bcd, fl_bcd, cut_cur, cut_tm;
  logic [13:0] man_sp;
  logic        man_ovr;

  logic [14:0] eq_t, fl_t;
  logic [20:0] eq98;
  logic [22:0] volt100;

  item_t cap;
  logic  match_hit;

  entry_t                   tbl [NUM_SCHEDULES];
  logic [NUM_SCHEDULES-1:0] tvalid;

  logic [1:0]         phase;
  logic               float_r, manual_r;
  logic [14:0]        setpoint;
  logic [DWELL_W-1:0] dwell;

  logic [1:0]         phase_next;
  logic               float_next, manual_next;
  logic [14:0]        setpoint_next;
  logic [DWELL_W-1:0] dwell_next;
  logic               applied_next, restart_next;

  entry_t      ent, new_ent;
  logic        ent_hit;
  logic        is_auto, is_man, is_load, low_cur, timed_out;
  logic [1:0]  ph_eff;
  logic [31:0] idx_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      eq_bcd  <= '0;
      fl_bcd  <= '0;
      man_sp  <= '0;
      man_ovr <= 1'b0;
      cut_cur <= '0;
      cut_tm  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EQUAL_SP:   eq_bcd  <= cfg_data;
        CFG_FLOAT_SP:   fl_bcd  <= cfg_data;
        CFG_MANUAL_SP:  man_sp  <= cfg_data[13:0];
        CFG_MANUAL_OVR: man_ovr <= cfg_data[0];
        CFG_CUT_CUR:    cut_cur <= cfg_data;
        CFG_CUT_TIME:   cut_tm  <= cfg_data;
        default: ;
      endcase
    end
  end

  // decoded setpoints and threshold products, refreshed every cycle
  always_ff @(posedge clk) begin
    eq_t    <= bcd_tenths(eq_bcd);
    fl_t    <= bcd_tenths(fl_bcd);
    eq98    <= 21'(eq_t) * 21'(EQ_PCT);
    volt100 <= 23'(cap.output_voltage) * 23'(VOLT_SCALE);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) cap <= item;
  end

  assign ent = tbl[cmd.scan_idx];
  assign ent_hit = tvalid[cmd.scan_idx]
                 && (ent.year  == '0 || ent.year  == cap.year)
                 && (ent.month == '0 || ent.month == cap.month)
                 && (ent.day   == '0 || ent.day   == cap.day)
                 && ent.hour == cap.hour && ent.minute == cap.minute
                 && ent.second == cap.second;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      match_hit <= 1'b0;
    end else if (cmd.scan_en && ent_hit) begin
      match_hit <= 1'b1;
    end
  end

  assign is_load   = (cap.kind == KIND_LOAD);
  assign is_auto   = (cap.kind == KIND_TICK) && !cap.manual_select;
  assign is_man    = (cap.kind == KIND_TICK) && cap.manual_select;
  assign idx_ext   = 32'(cap.entry_index);
  assign low_cur   = (cap.battery_current <= cut_cur) && (volt100 > 23'(eq98));
  assign timed_out = (cap.elapsed_cut_time >= cut_tm);

  assign new_ent.year   = cap.year;
  assign new_ent.month  = cap.month;
  assign new_ent.day    = cap.day;
  assign new_ent.hour   = cap.hour;
  assign new_ent.minute = cap.minute;
  assign new_ent.second = cap.second;

  always_ff @(posedge clk) begin
    if (cmd.commit && is_load && idx_ext < 32'(NUM_SCHEDULES)) begin
      tbl[idx_ext[IDX_W-1:0]] <= new_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= '0;
    end else if (cmd.commit && is_load && idx_ext < 32'(NUM_SCHEDULES)) begin
      tvalid[idx_ext[IDX_W-1:0]] <= 1'b1;
    end
  end

  always_comb begin
    restart_next  = is_auto && match_hit;
    ph_eff        = restart_next ? PH_WAIT : phase;
    phase_next    = phase;
    float_next    = float_r;
    manual_next   = manual_r;
    setpoint_next = setpoint;
    dwell_next    = dwell;
    applied_next  = 1'b0;
    if (is_auto) begin
      phase_next = ph_eff;
      case (ph_eff)
        PH_WAIT: begin
          phase_next    = PH_EQUALIZE;
          float_next    = 1'b0;
          manual_next   = 1'b0;
          setpoint_next = eq_t;
          applied_next  = 1'b1;
          dwell_next    = '0;
        end
        PH_EQUALIZE: begin
          if (dwell == DWELL_W'(DWELL_TICKS) && (low_cur || timed_out)) begin
            phase_next    = PH_DONE;
            float_next    = 1'b1;
            manual_next   = 1'b0;
            setpoint_next = fl_t;
            applied_next  = 1'b1;
          end else if (dwell != DWELL_W'(DWELL_TICKS)) begin
            dwell_next = dwell + DWELL_W'(1);
          end
        end
        default: dwell_next = '0;
      endcase
    end else if (is_man) begin
      dwell_next   = '0;
      manual_next  = 1'b1;
      applied_next = 1'b1;
      if (man_ovr) begin
        setpoint_next = {1'b0, man_sp};
      end else if (float_r) begin
        setpoint_next = fl_t;
      end else begin
        setpoint_next = eq_t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_WAIT;
      float_r  <= 1'b0;
      manual_r <= 1'b0;
      setpoint <= '0;
      dwell    <= '0;
    end else if (cmd.commit) begin
      phase    <= phase_next;
      float_r  <= float_next;
      manual_r <= manual_next;
      setpoint <= setpoint_next;
      dwell    <= dwell_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res.phase            <= phase_next;
      res.float_mode       <= float_next;
      res.manual_active    <= manual_next;
      res.voltage_setpoint <= setpoint_next;
      res.setpoint_applied <= applied_next;
      res.restart_timers   <= restart_next;
    end
  end

  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    phase != 2'd3)
    else $error("phase register holds an unused code");

  a_restart_applies: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && restart_next) |=>
      (res.setpoint_applied && res.phase == PH_EQUALIZE && !res.float_mode))
    else $error("schedule match did not restart equalize");

  a_dwell_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (dwell <= DWELL_W'(DWELL_TICKS)))
    else $error("dwell count past limit");

endmodule

[rtl/auto_charge_mode_controller.sv]
// Top level of the auto charge mode controller.
// Ties acmc_ctrl and acmc_dp to the channel interfaces. Depends on acmc_pkg, acmc_if.
//
//   channel   dir  handshake        carries
//   item      in   valid/ready      tick or schedule load transaction
//   result    out  valid/ready      phase, mode, setpoint, pulses
//   cfg       in   cfg_we           register index and data, no read-back
//
// Each transaction is accepted in the idle state, then passes a prep state, a scan
// of every table entry through a single read port, and a commit state that loads
// the result register; only back in idle is the next transaction accepted.
// The result sits in an output register; the next transaction is accepted while
// it waits, and only the commit cycle stalls on a full output register.
// Reset (rst, synchronous) clears config, mode state and table valid bits.
module auto_charge_mode_controller
  import acmc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  acmc_in_if.sink               item,
  acmc_out_if.source            result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;
  item_t     item_d;
  res_t      res;

  assign item_d.kind             = item.kind;
  assign item_d.entry_index      = item.entry_index;
  assign item_d.year             = item.year;
  assign item_d.month            = item.month;
  assign item_d.day              = item.day;
  assign item_d.hour             = item.hour;
  assign item_d.minute           = item.minute;
  assign item_d.second           = item.second;
  assign item_d.manual_select    = item.manual_select;
  assign item_d.battery_current  = item.battery_current;
  assign item_d.output_voltage   = item.output_voltage;
  assign item_d.elapsed_cut_time = item.elapsed_cut_time;

  acmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  acmc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item      (item_d),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  assign result.phase            = res.phase;
  assign result.float_mode       = res.float_mode;
  assign result.manual_active    = res.manual_active;
  assign result.voltage_setpoint = res.voltage_setpoint;
  assign result.setpoint_applied = res.setpoint_applied;
  assign result.restart_timers   = res.restart_timers;

endmodule
